// File: rtl/btbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block threshold bitmap packer package
// Shared sizes, register indexes and the item types passed between units.
// ----------------------------------------------------------------------------
package btbp_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned OUT_BYTES  = 200;
  localparam int unsigned BLOCK_COLS = (MAX_WIDTH + 3) / 4;
  localparam int unsigned MAX_CELLS  = OUT_BYTES * 8;

  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned BX_W       = $clog2(BLOCK_COLS);
  localparam int unsigned WIDTH_W    = 9;
  localparam int unsigned HEIGHT_W   = 11;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SEG_W      = 10;
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned IDX_W      = 8;

  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  // A classified pixel as handed from the front end to the back end.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             err;
    logic             seg_first;
    logic             col_end;
    logic             row_end;
    logic             frame_end;
    logic [BX_W-1:0]  bx;
    logic [CNT_W-1:0] count;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [7:0]       packed_byte;
    logic [IDX_W-1:0] byte_pos;
    logic             last_byte;
    logic             error;
  } word_t;

endpackage
`default_nettype wire

// File: rtl/block_threshold_bitmap_packer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: a word caused by an accepted pixel passes the item queue, the second
// stage and the word queue. The rate below holds while nothing stalls.
// Throughput: one pixel per cycle; a pixel needs at most one band-memory read
// and one write, made in different stages. The back end stalls only while its
// two-word queue is full, and full_o rises once the four-item queue fills.
// Reset: asynchronous and active low; width and height return to one and the
// frame position, bit packer and band sums start clean at once.
// ----------------------------------------------------------------------------
// Block threshold bitmap packer, top level
// Cuts a raster image into 4x4 blocks, sets a block's bit when twice its pixel
// sum reaches its pixel count, and packs one bit per block into bytes.
// ----------------------------------------------------------------------------
//
// Structure. The front end keeps the configuration and the raster position.
// For each pixel it works out whether it closes a block row segment, a block,
// or the frame, which block column it belongs to and how many pixels the
// (possibly clipped) block holds. These classified pixels go through a short
// queue to the back end.
//
// The back end has two stages. The first adds the pixel to the running sum of
// the current row segment and, at the end of a segment, reads the band sum of
// that block column from the band memory. The second adds the segment to
// the band sum, writes the result back (or zero once the block is finished),
// compares twice the sum against the pixel count and shifts the bit into the
// byte being packed. A write in the second stage is forwarded to a read issued
// in the same cycle for the same column. Memory entries carry valid bits, so a
// configuration write clears all band sums together.
//
// When the configuration is invalid every pixel becomes an error word with
// zeroed byte fields, and no frame state moves.
// ----------------------------------------------------------------------------
module block_threshold_bitmap_packer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  output logic                             full_o,
  input  logic [btbp_pkg::PIX_W-1:0]       pixel_i,
  input  logic                             pop_i,
  output logic                             empty_o,
  output logic [7:0]                       packed_byte_o,
  output logic [btbp_pkg::IDX_W-1:0]       byte_pos_o,
  output logic                             last_byte_o,
  output logic                             error_o,
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_idx_i,
  input  logic [btbp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import btbp_pkg::*;

  logic  q_push, q_full, q_pop, q_empty, cfg_clr;
  item_t q_in, q_out;

  btbp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .pixel_i    (pixel_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in),
    .cfg_clr_o  (cfg_clr)
  );

  btbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_out)
  );

  btbp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_clr_i     (cfg_clr),
    .q_empty_i     (q_empty),
    .q_item_i      (q_out),
    .q_pop_o       (q_pop),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .packed_byte_o (packed_byte_o),
    .byte_pos_o    (byte_pos_o),
    .last_byte_o   (last_byte_o),
    .error_o       (error_o)
  );

  assign full_o = q_full;

  // An error word never carries byte data.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && error_o) |-> (packed_byte_o == '0 && byte_pos_o == '0 && !last_byte_o))
    else $error("error word with byte data");

  // A frame never reaches beyond its byte budget.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (byte_pos_o < IDX_W'(OUT_BYTES)))
    else $error("byte position beyond frame");

  // The back end only takes from the item queue when it holds something.
  a_q_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("item queue read while empty");

endmodule
`default_nettype wire

// File: rtl/btbp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Holds the configuration and the raster position, and classifies pixels.
// ----------------------------------------------------------------------------
module btbp_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [btbp_pkg::PIX_W-1:0]       pixel_i,
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_idx_i,
  input  logic [btbp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output btbp_pkg::item_t                  q_item_o,
  output logic                             cfg_clr_o
);
  import btbp_pkg::*;

  logic [WIDTH_W-1:0]    width_q;
  logic [HEIGHT_W-1:0]   height_q;
  logic [COL_W-1:0]      col_q, col_d;
  logic [HEIGHT_W-1:0]   row_q, row_d;
  logic [WIDTH_W:0]      wplus;
  logic [HEIGHT_W:0]     hplus;
  logic [WIDTH_W-2:0]    bcols;
  logic [HEIGHT_W-2:0]   brows;
  logic [WIDTH_W+HEIGHT_W-3:0] cells;
  logic                  cfg_ok;
  logic                  accept;
  logic                  col_last, row_last;
  logic                  col_end, row_end, frame_end;
  logic [WIDTH_W-1:0]    cw_full;
  logic [HEIGHT_W-1:0]   rh_full;
  logic [2:0]            cw, rh;
  logic [5:0]            prod;

  // Validity of the current configuration.
  always_comb begin
    wplus  = {1'b0, width_q} + (WIDTH_W+1)'(3);
    hplus  = {1'b0, height_q} + (HEIGHT_W+1)'(3);
    bcols  = wplus[WIDTH_W:2];
    brows  = hplus[HEIGHT_W:2];
    cells  = {{(HEIGHT_W-1){1'b0}}, bcols} * {{(WIDTH_W-1){1'b0}}, brows};
    cfg_ok = (width_q != '0) && (width_q <= WIDTH_W'(MAX_WIDTH)) &&
             (height_q != '0) && (cells <= (WIDTH_W+HEIGHT_W-2)'(MAX_CELLS));
  end

  // Position flags and the pixel count of the current block.
  always_comb begin
    col_last  = (({1'b0, col_q} + WIDTH_W'(1)) >= width_q);
    row_last  = (({1'b0, row_q} + (HEIGHT_W+1)'(1)) >= {1'b0, height_q});
    col_end   = (col_q[1:0] == 2'b11) || col_last;
    row_end   = (row_q[1:0] == 2'b11) || row_last;
    frame_end = col_last && row_last;
    cw_full   = width_q - {1'b0, col_q[COL_W-1:2], 2'b00};
    rh_full   = height_q - {row_q[HEIGHT_W-1:2], 2'b00};
    cw        = (cw_full > WIDTH_W'(4)) ? 3'd4 : cw_full[2:0];
    rh        = (rh_full > HEIGHT_W'(4)) ? 3'd4 : rh_full[2:0];
    prod      = {3'b000, cw} * {3'b000, rh};
  end

  assign accept    = push_i && !q_full_i;
  assign q_push_o  = accept;
  assign cfg_clr_o = cfg_we_i;

  always_comb begin
    q_item_o.pixel     = pixel_i;
    q_item_o.err       = !cfg_ok;
    q_item_o.seg_first = (col_q[1:0] == 2'b00);
    q_item_o.col_end   = col_end;
    q_item_o.row_end   = row_end;
    q_item_o.frame_end = frame_end;
    q_item_o.bx        = col_q[COL_W-1:2];
    q_item_o.count     = prod[CNT_W-1:0];
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept && cfg_ok) begin
      if (frame_end) begin
        col_d = '0;
        row_d = '0;
      end else if (col_last) begin
        col_d = '0;
        row_d = row_q + HEIGHT_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_W'(1);
      height_q <= HEIGHT_W'(1);
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
          CFG_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
          default:    width_q  <= width_q;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/btbp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Item queue
// Short queue of classified pixels between the front end and the back end.
// ----------------------------------------------------------------------------
module btbp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  btbp_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output btbp_pkg::item_t item_o
);
  import btbp_pkg::*;

  item_t               slot_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QPTR_W:0]     cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (QPTR_W+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QPTR_W+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/btbp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Back end
// Accumulates block sums in a band memory, thresholds finished blocks, packs
// the cell bits into bytes and holds finished words in a two-entry queue.
// ----------------------------------------------------------------------------
module btbp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_clr_i,
  input  logic                      q_empty_i,
  input  btbp_pkg::item_t           q_item_i,
  output logic                      q_pop_o,
  input  logic                      pop_i,
  output logic                      empty_o,
  output logic [7:0]                packed_byte_o,
  output logic [btbp_pkg::IDX_W-1:0] byte_pos_o,
  output logic                      last_byte_o,
  output logic                      error_o
);
  import btbp_pkg::*;

  typedef struct packed {
    logic             err;
    logic             blk;
    logic             row_end;
    logic             frame_end;
    logic [BX_W-1:0]  bx;
    logic [CNT_W-1:0] count;
    logic [SEG_W-1:0] seg;
  } stage_t;

  logic [SUM_W-1:0]  sum_mem [BLOCK_COLS];
  logic [SUM_W-1:0]  rd_q;
  logic              rd_vld_q;
  logic [BLOCK_COLS-1:0] vld_q;
  logic              fwd_q;
  logic [BX_W-1:0]   fwd_bx_q;
  logic [SUM_W-1:0]  fwd_data_q;

  logic [SEG_W-1:0]  acc_q, acc_d;
  stage_t            b_q;
  logic              b_vld_q;
  logic              adv, mem_re, mem_we;
  logic [SUM_W-1:0]  old_sum, total, wdata;
  logic              cell_bit, block_done, emit;
  logic [7:0]        buf_q, buf_new;
  logic [2:0]        fill_q;
  logic [IDX_W-1:0]  bcnt_q;

  word_t             oq_q [2];
  logic              oq_wr_q, oq_rd_q;
  logic [1:0]        oq_cnt_q;
  logic              oq_push, oq_pop;
  word_t             oq_in;

  // The whole back end moves together whenever the word queue can take one.
  assign oq_pop  = pop_i && !empty_o;
  assign adv     = (oq_cnt_q != 2'd2) || oq_pop;
  assign q_pop_o = adv && !q_empty_i;
  assign mem_re  = q_pop_o && q_item_i.col_end && !q_item_i.err;

  // Row segment of the current block.
  assign acc_d = (q_item_i.seg_first ? '0 : acc_q) + {2'b00, q_item_i.pixel};

  always_comb begin
    if (fwd_q && (fwd_bx_q == b_q.bx)) begin
      old_sum = fwd_data_q;
    end else if (rd_vld_q) begin
      old_sum = rd_q;
    end else begin
      old_sum = '0;
    end
    total      = old_sum + {2'b00, b_q.seg};
    cell_bit   = ({total, 1'b0} >= {{(SUM_W+1-CNT_W){1'b0}}, b_q.count});
    block_done = b_q.blk && b_q.row_end;
    wdata      = b_q.row_end ? '0 : total;
    mem_we     = adv && b_vld_q && !b_q.err && b_q.blk;
    buf_new    = buf_q | (8'(cell_bit) << fill_q);
    emit       = b_q.err || (block_done && ((fill_q == 3'd7) || b_q.frame_end));
    oq_push    = adv && b_vld_q && emit;
    if (b_q.err) begin
      oq_in = '{packed_byte: '0, byte_pos: '0, last_byte: 1'b0, error: 1'b1};
    end else begin
      oq_in = '{packed_byte: buf_new, byte_pos: bcnt_q,
                last_byte: b_q.frame_end, error: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sum_mem[b_q.bx] <= wdata;
    end
    if (mem_re) begin
      rd_q <= sum_mem[q_item_i.bx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && !q_item_i.err) begin
      acc_q <= acc_d;
    end
    if (adv) begin
      b_q.err       <= q_item_i.err;
      b_q.blk       <= q_item_i.col_end;
      b_q.row_end   <= q_item_i.row_end;
      b_q.frame_end <= q_item_i.frame_end;
      b_q.bx        <= q_item_i.bx;
      b_q.count     <= q_item_i.count;
      b_q.seg       <= acc_d;
      fwd_bx_q      <= b_q.bx;
      fwd_data_q    <= wdata;
    end
    if (oq_push) begin
      oq_q[oq_wr_q] <= oq_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q   <= 1'b0;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      fwd_q     <= 1'b0;
      buf_q     <= '0;
      fill_q    <= '0;
      bcnt_q    <= '0;
    end else if (cfg_clr_i) begin
      b_vld_q   <= 1'b0;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      fwd_q     <= 1'b0;
      buf_q     <= '0;
      fill_q    <= '0;
      bcnt_q    <= '0;
    end else begin
      if (mem_we) begin
        vld_q[b_q.bx] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= vld_q[q_item_i.bx];
      end
      if (adv) begin
        b_vld_q <= q_pop_o;
        fwd_q   <= mem_we;
        if (b_vld_q && !b_q.err && block_done) begin
          if (b_q.frame_end) begin
            buf_q  <= '0;
            fill_q <= '0;
            bcnt_q <= '0;
          end else if (fill_q == 3'd7) begin
            buf_q  <= '0;
            fill_q <= '0;
            bcnt_q <= bcnt_q + IDX_W'(1);
          end else begin
            buf_q  <= buf_new;
            fill_q <= fill_q + 3'd1;
          end
        end
      end
    end
  end

  // Word queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_q <= !oq_wr_q;
      end
      if (oq_pop) begin
        oq_rd_q <= !oq_rd_q;
      end
      case ({oq_push, oq_pop})
        2'b10:   oq_cnt_q <= oq_cnt_q + 2'd1;
        2'b01:   oq_cnt_q <= oq_cnt_q - 2'd1;
        default: oq_cnt_q <= oq_cnt_q;
      endcase
    end
  end

  assign empty_o       = (oq_cnt_q == 2'd0);
  assign packed_byte_o = oq_q[oq_rd_q].packed_byte;
  assign byte_pos_o    = oq_q[oq_rd_q].byte_pos;
  assign last_byte_o   = oq_q[oq_rd_q].last_byte;
  assign error_o       = oq_q[oq_rd_q].error;

endmodule
`default_nettype wire
